// File: rtl/mnpg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mnpg_pkg;

	// field widths
	localparam int STATUS_W = 8;
	localparam int NOTE_W   = 7;
	localparam int VEL_W    = 7;
	localparam int COUNT_W  = 2;
	localparam int CHREG_W  = 8;
	localparam int PRIO_W   = 2;
	localparam int CFG_W    = 8;
	localparam int CFG_IDX_W = 3;

	// status opcodes and masks
	localparam logic [3:0] OP_NOTE_OFF = 4'h8;
	localparam logic [3:0] OP_NOTE_ON  = 4'h9;
	localparam logic [STATUS_W-1:0] CHAN_MASK = 8'h0f;
	localparam logic [CHREG_W-1:0]  VOICE_OFF = 8'hff;

	// byte counts needed per message kind
	localparam logic [COUNT_W-1:0] COUNT_OFF_MIN = 2'd2;
	localparam logic [COUNT_W-1:0] COUNT_ON_MIN  = 2'd3;

	// priority rule codes; the unused code acts as last note
	localparam logic [PRIO_W-1:0] PRIO_LAST   = 2'd0;
	localparam logic [PRIO_W-1:0] PRIO_HIGHER = 2'd1;
	localparam logic [PRIO_W-1:0] PRIO_LOWER  = 2'd2;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VOICE_A_CHAN = 3'd0,
		REG_VOICE_B_CHAN = 3'd1,
		REG_VOICE_A_PRIO = 3'd2,
		REG_VOICE_B_PRIO = 3'd3,
		REG_LOWEST_NOTE  = 3'd4,
		REG_HIGHEST_NOTE = 3'd5
	} cfg_reg_t;

	// per-voice state
	typedef struct packed {
		logic              playing;
		logic [NOTE_W-1:0] held;
	} voice_t;

	localparam voice_t VOICE_RESET = '{playing: 1'b0, held: '0};

endpackage

`default_nettype wire

// File: rtl/mnpg_if.sv
`timescale 1ns / 1ps
`default_nettype none

// incoming MIDI message channel
interface mnpg_msg_if;
	logic                         valid;
	logic                         ready;
	logic [mnpg_pkg::STATUS_W-1:0] status_byte;
	logic [mnpg_pkg::NOTE_W-1:0]   note_number;
	logic [mnpg_pkg::VEL_W-1:0]    velocity;
	logic [mnpg_pkg::COUNT_W-1:0]  byte_count;

	modport source (output valid, output status_byte, output note_number,
		output velocity, output byte_count, input ready);
	modport sink (input valid, input status_byte, input note_number,
		input velocity, input byte_count, output ready);
endinterface

// outgoing gate/pitch result channel
interface mnpg_res_if;
	logic                        valid;
	logic                        ready;
	logic                        gate_a;
	logic [mnpg_pkg::NOTE_W-1:0] pitch_a;
	logic                        gate_b;
	logic [mnpg_pkg::NOTE_W-1:0] pitch_b;
	logic                        was_note_message;

	modport source (output valid, output gate_a, output pitch_a, output gate_b,
		output pitch_b, output was_note_message, input ready);
	modport sink (input valid, input gate_a, input pitch_a, input gate_b,
		input pitch_b, input was_note_message, output ready);
endinterface

`default_nettype wire

// File: rtl/midi_note_priority_gate.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Handshake      Payload
// msg      in   valid/ready    status_byte, note_number, velocity, byte_count
// res      out  valid/ready    gate_a, pitch_a, gate_b, pitch_b, was_note_message
// cfg      in   cfg_wr_en      cfg_index, cfg_data (no wait, no read-back)
//
// One request per cycle sustained while res is ready; a request passes the input register,
// then the voice update into the result register, before res valid rises.
// Voice state updates as a request moves from the input register to the result
// register, so the next request sees it at once.
// A stalled res holds its register; the input register then holds and msg drops ready.
// arst_n clears the voice state and the valid flags and returns the configuration
// registers to their reset values.

module midi_note_priority_gate (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wr_en,
	input  wire logic [mnpg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [mnpg_pkg::CFG_W-1:0]      cfg_data,
	mnpg_msg_if.sink                             msg,
	mnpg_res_if.source                           res
);

	// configuration registers
	logic [mnpg_pkg::CHREG_W-1:0] chan_a_q, chan_b_q;
	logic [mnpg_pkg::PRIO_W-1:0]  prio_a_q, prio_b_q;
	logic [mnpg_pkg::NOTE_W-1:0]  lowest_q, highest_q;

	// input register
	logic                          valid_s1;
	logic [mnpg_pkg::STATUS_W-1:0] status_s1;
	logic [mnpg_pkg::NOTE_W-1:0]   note_s1;
	logic [mnpg_pkg::VEL_W-1:0]    vel_s1;
	logic [mnpg_pkg::COUNT_W-1:0]  count_s1;

	// voice state and result register
	mnpg_pkg::voice_t voice_a_q, voice_b_q;
	mnpg_pkg::voice_t voice_a_next, voice_b_next;
	logic             res_valid_q;
	logic             note_msg_q;

	logic             advance;
	logic             is_off, is_on;
	logic [3:0]       opcode;
	logic [mnpg_pkg::STATUS_W-1:0] chan;

	// next state of one voice for the request in the input register
	function automatic mnpg_pkg::voice_t voice_step(
		input mnpg_pkg::voice_t             cur,
		input logic [mnpg_pkg::CHREG_W-1:0] chreg,
		input logic [mnpg_pkg::PRIO_W-1:0]  prio,
		input logic [mnpg_pkg::STATUS_W-1:0] ch,
		input logic                         off,
		input logic                         on,
		input logic [mnpg_pkg::NOTE_W-1:0]  note,
		input logic [mnpg_pkg::VEL_W-1:0]   vel,
		input logic [mnpg_pkg::NOTE_W-1:0]  lo,
		input logic [mnpg_pkg::NOTE_W-1:0]  hi
	);
		mnpg_pkg::voice_t nxt;
		logic             ignore;
		nxt    = cur;
		ignore = 1'b0;
		if (chreg != mnpg_pkg::VOICE_OFF && chreg == ch) begin
			if (off || (on && vel == '0)) begin
				// note-off drops the gate and clears the held note
				if (cur.playing) begin
					nxt.playing = 1'b0;
					nxt.held    = '0;
				end
			end else if (on) begin
				// priority rule may ignore the new note while playing
				if (cur.playing) begin
					if (prio == mnpg_pkg::PRIO_HIGHER && cur.held >= note)
						ignore = 1'b1;
					if (prio == mnpg_pkg::PRIO_LOWER && cur.held <= note)
						ignore = 1'b1;
				end
				if (!ignore) begin
					if (note >= lo && note <= hi) begin
						nxt.playing = 1'b1;
						nxt.held    = note;
					end else begin
						nxt.playing = 1'b0;
					end
				end
			end
		end
		return nxt;
	endfunction

	// decode the held request
	always_comb begin
		opcode = status_s1[mnpg_pkg::STATUS_W-1 -: 4];
		chan   = status_s1 & mnpg_pkg::CHAN_MASK;
		is_off = count_s1 >= mnpg_pkg::COUNT_OFF_MIN && opcode == mnpg_pkg::OP_NOTE_OFF;
		is_on  = count_s1 >= mnpg_pkg::COUNT_ON_MIN && opcode == mnpg_pkg::OP_NOTE_ON;
		voice_a_next = voice_step(voice_a_q, chan_a_q, prio_a_q, chan, is_off, is_on,
			note_s1, vel_s1, lowest_q, highest_q);
		voice_b_next = voice_step(voice_b_q, chan_b_q, prio_b_q, chan, is_off, is_on,
			note_s1, vel_s1, lowest_q, highest_q);
	end

	// advance when the result register is free or being emptied
	assign advance   = valid_s1 && (!res_valid_q || res.ready);
	assign msg.ready = !valid_s1 || advance;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_a_q  <= 8'd0;
			chan_b_q  <= 8'd1;
			prio_a_q  <= mnpg_pkg::PRIO_LAST;
			prio_b_q  <= mnpg_pkg::PRIO_LAST;
			lowest_q  <= 7'd0;
			highest_q <= 7'd127;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				mnpg_pkg::REG_VOICE_A_CHAN: chan_a_q  <= cfg_data;
				mnpg_pkg::REG_VOICE_B_CHAN: chan_b_q  <= cfg_data;
				mnpg_pkg::REG_VOICE_A_PRIO: prio_a_q  <= cfg_data[mnpg_pkg::PRIO_W-1:0];
				mnpg_pkg::REG_VOICE_B_PRIO: prio_b_q  <= cfg_data[mnpg_pkg::PRIO_W-1:0];
				mnpg_pkg::REG_LOWEST_NOTE:  lowest_q  <= cfg_data[mnpg_pkg::NOTE_W-1:0];
				mnpg_pkg::REG_HIGHEST_NOTE: highest_q <= cfg_data[mnpg_pkg::NOTE_W-1:0];
				default: ;
			endcase
		end
	end

	// input register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (msg.ready)
			valid_s1 <= msg.valid;
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (msg.valid && msg.ready) begin
			status_s1 <= msg.status_byte;
			note_s1   <= msg.note_number;
			vel_s1    <= msg.velocity;
			count_s1  <= msg.byte_count;
		end
	end

	// update voice state as the request leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			voice_a_q <= mnpg_pkg::VOICE_RESET;
			voice_b_q <= mnpg_pkg::VOICE_RESET;
		end else if (advance) begin
			voice_a_q <= voice_a_next;
			voice_b_q <= voice_b_next;
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (advance)
			res_valid_q <= 1'b1;
		else if (res.ready)
			res_valid_q <= 1'b0;
	end

	// message kind flag of the result
	always_ff @(posedge clk) begin
		if (advance)
			note_msg_q <= is_on || is_off;
	end

	// drive the result channel from the registered state
	assign res.valid            = res_valid_q;
	assign res.gate_a           = voice_a_q.playing;
	assign res.pitch_a          = voice_a_q.held;
	assign res.gate_b           = voice_b_q.playing;
	assign res.pitch_b          = voice_b_q.held;
	assign res.was_note_message = note_msg_q;

endmodule

`default_nettype wire

// File: tb/mnpg_voice_monitor.sv
`timescale 1ns / 1ps

module mnpg_voice_monitor import mnpg_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	mnpg_msg_if                       msg,
	mnpg_res_if                       res,
	output int                        mismatches,
	output int                        pending
);

	typedef struct packed {
		logic              gate_a;
		logic [NOTE_W-1:0] pitch_a;
		logic              gate_b;
		logic [NOTE_W-1:0] pitch_b;
		logic              note_msg;
	} voice_report_t;

	// shadow copy of the configuration registers
	logic [CHREG_W-1:0] chan_a_reg;
	logic [CHREG_W-1:0] chan_b_reg;
	logic [PRIO_W-1:0]  prio_a_reg;
	logic [PRIO_W-1:0]  prio_b_reg;
	logic [NOTE_W-1:0]  low_note;
	logic [NOTE_W-1:0]  high_note;

	voice_t        voice_a;
	voice_t        voice_b;
	voice_report_t expected_reports[$];
	voice_report_t want;

	// update one voice for a note-on or note-off on MIDI channel chan
	function automatic voice_t apply_to_voice(voice_t v, logic [CHREG_W-1:0] chreg,
			logic [PRIO_W-1:0] prio, logic [STATUS_W-1:0] chan, logic is_off,
			logic is_on, logic [NOTE_W-1:0] nn, logic [VEL_W-1:0] vel);
		if (chreg == VOICE_OFF || chreg != chan)
			return v;
		if (is_off || (is_on && vel == '0)) begin
			if (v.playing)
				v = VOICE_RESET;
		end else if (is_on) begin
			// a playing voice keeps its note when the new one loses on priority
			if (v.playing && prio == PRIO_HIGHER && v.held >= nn)
				return v;
			if (v.playing && prio == PRIO_LOWER && v.held <= nn)
				return v;
			if (nn >= low_note && nn <= high_note) begin
				v.playing = 1'b1;
				v.held = nn;
			end else begin
				v.playing = 1'b0;
			end
		end
		return v;
	endfunction

	// advance both voices for one request and build the report it should yield
	function automatic voice_report_t predict_report(logic [STATUS_W-1:0] st,
			logic [NOTE_W-1:0] nn, logic [VEL_W-1:0] vel, logic [COUNT_W-1:0] cnt);
		logic          is_off;
		logic          is_on;
		voice_report_t r;
		is_off = cnt >= COUNT_OFF_MIN && st[7:4] == OP_NOTE_OFF;
		is_on = cnt >= COUNT_ON_MIN && st[7:4] == OP_NOTE_ON;
		if (is_on || is_off) begin
			voice_a = apply_to_voice(voice_a, chan_a_reg, prio_a_reg, st & CHAN_MASK,
				is_off, is_on, nn, vel);
			voice_b = apply_to_voice(voice_b, chan_b_reg, prio_b_reg, st & CHAN_MASK,
				is_off, is_on, nn, vel);
		end
		r.gate_a = voice_a.playing;
		r.pitch_a = voice_a.held;
		r.gate_b = voice_b.playing;
		r.pitch_b = voice_b.held;
		r.note_msg = is_on || is_off;
		return r;
	endfunction

	task automatic check_field(string field, int exp_val, int got_val);
		if (exp_val != got_val) begin
			$error("%s: expected %0d, got %0d", field, exp_val, got_val);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_a_reg = 8'd0;
			chan_b_reg = 8'd1;
			prio_a_reg = PRIO_LAST;
			prio_b_reg = PRIO_LAST;
			low_note = 7'd0;
			high_note = 7'd127;
			voice_a = VOICE_RESET;
			voice_b = VOICE_RESET;
			expected_reports.delete();
			mismatches = 0;
			pending = 0;
		end else begin
			// track register writes
			if (cfg_wr_en) begin
				case (cfg_reg_t'(cfg_index))
					REG_VOICE_A_CHAN: chan_a_reg = cfg_data[CHREG_W-1:0];
					REG_VOICE_B_CHAN: chan_b_reg = cfg_data[CHREG_W-1:0];
					REG_VOICE_A_PRIO: prio_a_reg = cfg_data[PRIO_W-1:0];
					REG_VOICE_B_PRIO: prio_b_reg = cfg_data[PRIO_W-1:0];
					REG_LOWEST_NOTE:  low_note = cfg_data[NOTE_W-1:0];
					REG_HIGHEST_NOTE: high_note = cfg_data[NOTE_W-1:0];
					default: ;
				endcase
			end

			// compare each accepted result with the oldest expectation
			if (res.valid && res.ready) begin
				if (expected_reports.size() == 0) begin
					$error("result accepted with nothing expected");
					mismatches++;
				end else begin
					want = expected_reports.pop_front();
					check_field("gate_a", want.gate_a, res.gate_a);
					check_field("pitch_a", want.pitch_a, res.pitch_a);
					check_field("gate_b", want.gate_b, res.gate_b);
					check_field("pitch_b", want.pitch_b, res.pitch_b);
					check_field("was_note_message", want.note_msg, res.was_note_message);
				end
			end

			// predict on each accepted request
			if (msg.valid && msg.ready)
				expected_reports.push_back(predict_report(msg.status_byte, msg.note_number,
					msg.velocity, msg.byte_count));

			pending = expected_reports.size();
		end
	end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
	import mnpg_pkg::*;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	int                   errors;
	int                   pending;
	int                   send_idle;
	int                   recv_idle;

	// register values currently programmed, used to steer the random traffic
	logic [CHREG_W-1:0] cur_chan_a;
	logic [CHREG_W-1:0] cur_chan_b;
	logic [NOTE_W-1:0]  cur_low;
	logic [NOTE_W-1:0]  cur_high;

	mnpg_msg_if msg_ch ();
	mnpg_res_if res_ch ();

	midi_note_priority_gate DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.msg       (msg_ch),
		.res       (res_ch)
	);

	mnpg_voice_monitor u_monitor (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.msg        (msg_ch),
		.res        (res_ch),
		.mismatches (errors),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#400000;
		$display("tb: done, errors");
		$finish;
	end

	// stall the result side at random
	always @(posedge clk) begin
		res_ch.ready <= ($urandom_range(99) >= recv_idle);
	end

	// offer one request, idling first at random; leave valid high on return
	task automatic send_msg(input logic [STATUS_W-1:0] st, input logic [NOTE_W-1:0] nn,
			input logic [VEL_W-1:0] vel, input logic [COUNT_W-1:0] cnt);
		logic hit;
		while ($urandom_range(99) < send_idle) begin
			msg_ch.valid <= 1'b0;
			@(posedge clk);
		end
		msg_ch.valid <= 1'b1;
		msg_ch.status_byte <= st;
		msg_ch.note_number <= nn;
		msg_ch.velocity <= vel;
		msg_ch.byte_count <= cnt;
		do begin
			@(negedge clk);
			hit = msg_ch.ready;
			@(posedge clk);
		end while (!hit);
	endtask

	// hold off until every result is back and the pipeline is empty
	task automatic drain();
		msg_ch.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
	endtask

	// write all six registers on consecutive edges
	task automatic set_config(input logic [7:0] chan_a, input logic [7:0] chan_b,
			input logic [7:0] prio_a, input logic [7:0] prio_b, input logic [7:0] lo,
			input logic [7:0] hi);
		logic [CFG_W-1:0] vals[6];
		vals = '{chan_a, chan_b, prio_a, prio_b, lo, hi};
		for (int i = 0; i < 6; i++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= cfg_reg_t'(i);
			cfg_data <= vals[i];
			@(posedge clk);
		end
		cfg_wr_en <= 1'b0;
		cur_chan_a = chan_a;
		cur_chan_b = chan_b;
		cur_low = lo[NOTE_W-1:0];
		cur_high = hi[NOTE_W-1:0];
	endtask

	function automatic logic [7:0] random_chan();
		int r;
		r = $urandom_range(99);
		if (r < 85)
			return 8'($urandom_range(15));
		if (r < 93)
			return VOICE_OFF;
		return 8'($urandom_range(254, 16));
	endfunction

	// pick a setting per block: a few fixed corners, the rest random
	task automatic block_config(input int blk);
		int r;
		int na;
		int nb;
		case (blk)
			0: set_config(0, 0, PRIO_HIGHER, PRIO_LOWER, 0, 127);
			3: set_config(15, 15, 3, PRIO_LAST, 127, 127);
			6: set_config(VOICE_OFF, 2, PRIO_LOWER, PRIO_HIGHER, 0, 0);
			9: set_config(16, 3, PRIO_LAST, 3, 127, 0);
			default: begin
				r = $urandom_range(99);
				na = $urandom_range(127);
				nb = $urandom_range(127);
				if (r < 10) begin
					na = 0;
					nb = 127;
				end else if ((r < 25) == (na < nb)) begin
					// reversed range for r < 25, ordered otherwise
					na = na + nb;
					nb = na - nb;
					na = na - nb;
				end
				set_config(random_chan(), random_chan(), 8'($urandom_range(3)),
					8'($urandom_range(3)), 8'(na), 8'(nb));
			end
		endcase
	endtask

	// mostly note traffic aimed at the programmed voices, some noise
	task automatic random_msg();
		logic [3:0]          op;
		logic [3:0]          chan;
		logic [NOTE_W-1:0]   nn;
		logic [VEL_W-1:0]    vel;
		logic [COUNT_W-1:0]  cnt;
		if ($urandom_range(99) < 12) begin
			send_msg(8'($urandom_range(255)), 7'($urandom_range(127)),
				7'($urandom_range(127)), 2'($urandom_range(3)));
			return;
		end
		op = ($urandom_range(99) < 60) ? OP_NOTE_ON : OP_NOTE_OFF;
		case ($urandom_range(3))
			0, 3: chan = cur_chan_a[3:0];
			1: chan = cur_chan_b[3:0];
			default: chan = 4'($urandom_range(15));
		endcase
		if (cur_low <= cur_high && $urandom_range(99) < 80)
			nn = 7'($urandom_range(cur_high, cur_low));
		else
			nn = 7'($urandom_range(127));
		if (op == OP_NOTE_ON) begin
			vel = ($urandom_range(99) < 10) ? 7'd0 : 7'($urandom_range(127, 1));
			cnt = ($urandom_range(99) < 90) ? 2'd3 : 2'($urandom_range(3));
		end else begin
			vel = 7'($urandom_range(127));
			cnt = ($urandom_range(99) < 90) ? 2'($urandom_range(3, 2)) : 2'($urandom_range(3));
		end
		send_msg({op, chan}, nn, vel, cnt);
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		msg_ch.valid <= 1'b0;
		msg_ch.status_byte <= '0;
		msg_ch.note_number <= '0;
		msg_ch.velocity <= '0;
		msg_ch.byte_count <= '0;
		cur_chan_a = 8'd0;
		cur_chan_b = 8'd1;
		cur_low = 7'd0;
		cur_high = 7'd127;
		send_idle = 24;
		recv_idle = 68;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setting: last note wins, full range, voices on channels 0 and 1
		send_msg(8'h90, 7'd60, 7'd100, 2'd3);
		send_msg(8'h90, 7'd127, 7'd127, 2'd3);
		send_msg(8'h91, 7'd0, 7'd1, 2'd3);
		send_msg(8'h80, 7'd5, 7'd0, 2'd2);
		send_msg(8'h80, 7'd5, 7'd0, 2'd3);
		send_msg(8'h91, 7'd0, 7'd0, 2'd3);
		send_msg(8'h90, 7'd64, 7'd64, 2'd2);
		send_msg(8'h80, 7'd64, 7'd64, 2'd1);
		send_msg(8'h90, 7'd64, 7'd64, 2'd0);
		send_msg(8'hA0, 7'd64, 7'd64, 2'd3);
		send_msg(8'hFF, 7'd127, 7'd127, 2'd3);
		send_msg(8'h00, 7'd0, 7'd0, 2'd0);
		send_msg(8'h9F, 7'd33, 7'd90, 2'd3);

		// higher note on A, lower note on B, shared channel, narrow range
		drain();
		set_config(5, 5, PRIO_HIGHER, PRIO_LOWER, 20, 100);
		send_msg(8'h95, 7'd50, 7'd80, 2'd3);
		send_msg(8'h95, 7'd40, 7'd80, 2'd3);
		send_msg(8'h95, 7'd60, 7'd80, 2'd3);
		send_msg(8'h95, 7'd10, 7'd80, 2'd3);
		send_msg(8'h95, 7'd127, 7'd80, 2'd3);
		send_msg(8'h95, 7'd100, 7'd80, 2'd3);
		send_msg(8'h85, 7'd0, 7'd0, 2'd2);

		// unused priority code on A, B disabled
		drain();
		set_config(7, VOICE_OFF, 3, PRIO_LAST, 30, 90);
		send_msg(8'h97, 7'd50, 7'd1, 2'd3);
		send_msg(8'h97, 7'd40, 7'd1, 2'd3);
		send_msg(8'h97, 7'd30, 7'd1, 2'd3);

		// random traffic under three idle patterns, four settings each
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle = 24;
					recv_idle = 68;
				end
				1: begin
					send_idle = 68;
					recv_idle = 24;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase
			for (int k = 0; k < 4; k++) begin
				drain();
				block_config(ph * 4 + k);
				repeat (94) random_msg();
			end
		end

		drain();
		if (errors == 0 && pending == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
